// ===== hw/rtl/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types for the sorted list engine
// Operation and status codes, and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_RSTPOS   = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  // cmp: latch compare flags; ins / del: shift the row
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sle_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted row
// Holds one entry, registers its compare flags against the operand and takes
// its neighbor's entry, or the operand on an insert, when the row shifts for an insert or a delete.
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  sle_pkg::cell_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   valid,
  input  logic                   prev_s,
  input  logic [VALUE_WIDTH-1:0] prev_entry,
  input  logic [VALUE_WIDTH-1:0] next_entry,
  output logic [VALUE_WIDTH-1:0] entry,
  output logic                   s_flag,
  output logic                   ge_flag,
  output logic                   eq_flag
);

  logic [VALUE_WIDTH-1:0] entry_next;

  // s_flag: an insert lands at or before this slot (empty slots count as +inf)
  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (prev_s) begin
        entry_next = prev_entry;
      end else if (s_flag) begin
        entry_next = value;
      end
    end else if (ctl.del && ge_flag) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctl.cmp) begin
      s_flag  <= !valid || (entry > value);
      ge_flag <= valid && (entry >= value);
      eq_flag <= valid && (entry == value);
    end
  end

endmodule

// ===== hw/rtl/sorted_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_top: bounded ascending table of unsigned values
// Usage: a request beat (func, value) is taken on req_valid with req_stall low.
// One response beat (status, found, read_value, entry_total) follows for every
// request, in order, on rsp_valid / rsp_stall.
// A request passes the compare state and then the update state, which writes the
// response register. A new request can be taken in the update state of the
// previous one. The compare state latches the compare flags of every cell of
// the row against the operand, the update state reduces the match flags, moves
// the read position and shifts the row of cells. The request side is stalled
// during the compare cycle, and in the update cycle while a previous response
// still waits on a stalled receiver; one response register parts the two sides.
// Reset (rst, synchronous) empties the table and sets the read position to
// end; stored entries are not cleared, only those below the count are read.
// A stalled response holds its payload until taken.
// ----------------------------------------------------------------------------
module sorted_list_engine_top #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  func,
  input  logic [31:0] value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic        found,
  output logic [31:0] read_value,
  output logic [6:0]  entry_total
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count / position
  localparam int unsigned IW = $clog2(CAPACITY);      // cell index

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t                 state;
  sle_pkg::op_t           op;
  logic [VALUE_WIDTH-1:0] op_val;
  logic [CW-1:0]          count;
  logic [CW-1:0]          pos;

  // operand narrowed or widened to the stored width
  logic [63:0]            v_wide;
  logic [VALUE_WIDTH-1:0] v_in;

  // the row of cells
  sle_pkg::cell_ctl_t     ctl;
  logic [VALUE_WIDTH-1:0] entry_arr [CAPACITY];
  logic [CAPACITY-1:0]    valid_vec;
  logic [CAPACITY-1:0]    s_vec;
  logic [CAPACITY-1:0]    ge_vec;
  logic [CAPACITY-1:0]    eq_vec;
  logic [CAPACITY:0]      s_ext;
  logic [CAPACITY:0]      ge_ext;

  // update cycle results
  logic                   can_write;
  logic                   upd_fire;
  logic                   any_eq;
  logic                   full;
  logic                   at_end;
  logic [63:0]            rd_wide;
  sle_pkg::status_t       status_next;
  logic                   found_next;
  logic [31:0]            rd_next;
  logic [CW-1:0]          count_next;
  logic [CW-1:0]          pos_next;

  assign v_wide = {32'b0, value};
  assign v_in   = v_wide[VALUE_WIDTH-1:0];

  assign can_write = !rsp_valid || !rsp_stall;
  assign upd_fire  = (state == S_UPD) && can_write;
  assign req_stall = !((state == S_IDLE) || upd_fire);

  assign any_eq = |eq_vec;
  assign full   = (count >= CW'(CAPACITY));
  assign at_end = (pos >= count);

  // position lookups: the slot at pos, and the slot just below it
  assign s_ext  = {1'b1, s_vec};
  assign ge_ext = {ge_vec, 1'b0};

  always_comb begin
    ctl.cmp = (state == S_CMP);
    ctl.ins = upd_fire && (op == sle_pkg::OP_INSERT) && !full;
    ctl.del = upd_fire && (op == sle_pkg::OP_DELETE) && any_eq;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic                   prev_s;
      logic [VALUE_WIDTH-1:0] prev_entry;
      logic [VALUE_WIDTH-1:0] next_entry;

      assign valid_vec[g] = (count > CW'(g));

      if (g == 0) begin : g_first
        assign prev_s     = 1'b0;
        assign prev_entry = entry_arr[g];
      end else begin : g_mid
        assign prev_s     = s_vec[g-1];
        assign prev_entry = entry_arr[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign next_entry = entry_arr[g];
      end else begin : g_inner
        assign next_entry = entry_arr[g+1];
      end

      sle_cell #(
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .value      (op_val),
        .valid      (valid_vec[g]),
        .prev_s     (prev_s),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .entry      (entry_arr[g]),
        .s_flag     (s_vec[g]),
        .ge_flag    (ge_vec[g]),
        .eq_flag    (eq_vec[g])
      );
    end
  endgenerate

  assign rd_wide = 64'(entry_arr[pos[IW-1:0]]);

  always_comb begin
    status_next = sle_pkg::ST_OK;
    found_next  = 1'b0;
    rd_next     = 32'd0;
    count_next  = count;
    pos_next    = pos;
    case (op)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          status_next = sle_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
          // new entry lands at or before the position: follow it
          if (s_ext[pos]) begin
            pos_next = pos + CW'(1);
          end
        end
      end
      sle_pkg::OP_DELETE: begin
        if (any_eq) begin
          found_next = 1'b1;
          count_next = count - CW'(1);
          // removed entry sits below the position
          if (ge_ext[pos]) begin
            pos_next = pos - CW'(1);
          end
        end else begin
          status_next = sle_pkg::ST_NOTFOUND;
        end
      end
      sle_pkg::OP_CONTAINS: begin
        found_next = any_eq;
        if (!any_eq) begin
          status_next = sle_pkg::ST_NOTFOUND;
        end
      end
      sle_pkg::OP_CLEAR: begin
        count_next = '0;
        pos_next   = '0;
      end
      sle_pkg::OP_RSTPOS: begin
        pos_next = '0;
      end
      sle_pkg::OP_READ: begin
        if (at_end) begin
          status_next = sle_pkg::ST_PAST_END;
        end else begin
          rd_next  = rd_wide[31:0];
          pos_next = pos + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
      pos       <= '0;
    end else begin
      if (upd_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op     <= sle_pkg::op_t'(func);
            op_val <= v_in;
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (can_write) begin
            status      <= status_next;
            found       <= found_next;
            read_value  <= rd_next;
            entry_total <= 7'(count_next);
            count       <= count_next;
            pos         <= pos_next;
            if (req_valid) begin
              op     <= sle_pkg::op_t'(func);
              op_val <= v_in;
              state  <= S_CMP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= count)
    else $error("read position beyond entry count");

  a_rsp_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_UPD))
    else $error("response raised outside the update cycle");

  a_no_accept_in_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> req_stall)
    else $error("request taken during the compare cycle");
`endif

endmodule
